>>> rtl/core/prtti_pkg.sv
// ----------------------------------------------------------------------------
// prtti_pkg
// Shared types, register indexes, mode codes and the digit decoder for the
// padded radix text to integer parser.
// ----------------------------------------------------------------------------
package prtti_pkg;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NUMBER_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FILL_CHAR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MINUS_CHAR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PLUS_CHAR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_MODE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LETTER_CASE = 3'd5;

   // Pad mode codes; the spare code behaves as no fill skipping
   localparam logic [1:0] PAD_SIGN_FILL = 2'd0;
   localparam logic [1:0] PAD_FILL_SIGN = 2'd1;
   localparam logic [1:0] PAD_NO_FILL   = 2'd2;

   // Letter case codes; the spare code behaves as upper only
   localparam logic [1:0] CASE_ANY   = 2'd0;
   localparam logic [1:0] CASE_LOWER = 2'd1;
   localparam logic [1:0] CASE_UPPER = 2'd2;

   // Character and radix constants
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] UPPER_OFS    = 8'd55;
   localparam logic [7:0] LOWER_OFS    = 8'd87;
   localparam logic [5:0] BASE_MIN     = 6'd2;
   localparam logic [5:0] BASE_MAX     = 6'd36;
   localparam logic [5:0] BASE_DEC     = 6'd10;

   // Reset values of the registers
   localparam logic [5:0] RST_NUMBER_BASE = 6'd10;
   localparam logic [7:0] RST_FILL_CHAR   = 8'd48;
   localparam logic [7:0] RST_MINUS_CHAR  = 8'd45;
   localparam logic [7:0] RST_PLUS_CHAR   = 8'd43;
   localparam logic [1:0] RST_PAD_MODE    = PAD_FILL_SIGN;
   localparam logic [1:0] RST_LETTER_CASE = CASE_ANY;

   typedef struct packed {
      logic [5:0] number_base;
      logic [7:0] fill_char;
      logic [7:0] minus_char;
      logic [7:0] plus_char;
      logic [1:0] pad_mode;
      logic [1:0] letter_case;
   } cfg_type;

   // Decode one character as a digit of base b: bit 6 flags a digit,
   // bits 5:0 carry its value
   function automatic logic [6:0] digit_decode(input logic [7:0] c,
                                               input logic [5:0] b,
                                               input logic [1:0] lc);
      logic [8:0] c_w;
      logic [8:0] lim_num;
      logic [8:0] lim_up;
      logic [8:0] lim_lo;
      logic [7:0] d_num;
      logic [7:0] d_up;
      logic [7:0] d_lo;
      logic [6:0] res;
      c_w     = {1'b0, c};
      lim_num = {1'b0, CHAR_ZERO} + {3'b000, b};
      lim_up  = {1'b0, UPPER_OFS} + {3'b000, b};
      lim_lo  = {1'b0, LOWER_OFS} + {3'b000, b};
      d_num   = c - CHAR_ZERO;
      d_up    = c - UPPER_OFS;
      d_lo    = c - LOWER_OFS;
      res     = '0;
      if (b <= BASE_DEC) begin
         if (c >= CHAR_ZERO && c_w < lim_num) begin
            res = {1'b1, d_num[5:0]};
         end
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         res = {1'b1, d_num[5:0]};
      end else if (lc != CASE_LOWER && c >= CHAR_UPPER_A && c_w < lim_up) begin
         res = {1'b1, d_up[5:0]};
      end else if ((lc == CASE_ANY || lc == CASE_LOWER) && c >= CHAR_LOWER_A &&
                   c_w < lim_lo) begin
         res = {1'b1, d_lo[5:0]};
      end
      return res;
   endfunction

endpackage

>>> rtl/core/padded_radix_text_to_integer.sv
// Path: a character accepted into the input item register is parsed from there;
// a result it ends is loaded into the result register, which drives rsp_valid.
// Throughput: one character per cycle, set by the combinational multiply-add
// that closes the accumulator loop; input stalls only behind a held result.
// Reset: synchronous; clears both item valid flags and the parser state and
// loads the register defaults (base 10, fill '0', signs '-' and '+').
// ----------------------------------------------------------------------------
// padded_radix_text_to_integer
// Streaming parser of signed integers in base 2 to 36 with fill skipping,
// one ASCII character per item, one result per terminator or per bad-base item.
// ----------------------------------------------------------------------------
module padded_radix_text_to_integer
   import prtti_pkg::*;
#(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_ch,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_value,
   output logic [COUNT_WIDTH-1:0] rsp_consumed,
   output logic                   rsp_config_error,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type                cfg;
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_ch_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic [COUNT_WIDTH-1:0] out_count_ff;
   logic                   out_error_ff;
   logic                   emit;
   logic [VALUE_WIDTH-1:0] res_value;
   logic [COUNT_WIDTH-1:0] res_count;
   logic                   res_error;
   logic                   consume;
   logic                   accept;

   prtti_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   prtti_core #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (consume),
      .ch        (in_ch_ff),
      .emit      (emit),
      .res_value (res_value),
      .res_count (res_count),
      .res_error (res_error)
   );

   // Process the held item unless its result would overrun a stalled output
   assign consume   = in_valid_ff && (!emit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   // Input item register
   assign in_valid_in = accept ? 1'b1 : (consume ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff <= req_ch;
      end
   end

   // Result register: hold while stalled, load when a terminator or bad base is parsed
   assign out_valid_in = (out_valid_ff && rsp_stall) || (consume && emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && emit) begin
         out_value_ff <= res_value;
         out_count_ff <= res_count;
         out_error_ff <= res_error;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_value        = out_value_ff;
   assign rsp_consumed     = out_count_ff;
   assign rsp_config_error = out_error_ff;

endmodule

>>> rtl/core/prtti_csr.sv
// ----------------------------------------------------------------------------
// prtti_csr
// Configuration register file: six registers written by index, always ready.
// ----------------------------------------------------------------------------
module prtti_csr
   import prtti_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_NUMBER_BASE: cfg_in.number_base = csr_data[5:0];
            REG_FILL_CHAR:   cfg_in.fill_char   = csr_data;
            REG_MINUS_CHAR:  cfg_in.minus_char  = csr_data;
            REG_PLUS_CHAR:   cfg_in.plus_char   = csr_data;
            REG_PAD_MODE:    cfg_in.pad_mode    = csr_data[1:0];
            REG_LETTER_CASE: cfg_in.letter_case = csr_data[1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.number_base <= RST_NUMBER_BASE;
         cfg_ff.fill_char   <= RST_FILL_CHAR;
         cfg_ff.minus_char  <= RST_MINUS_CHAR;
         cfg_ff.plus_char   <= RST_PLUS_CHAR;
         cfg_ff.pad_mode    <= RST_PAD_MODE;
         cfg_ff.letter_case <= RST_LETTER_CASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/prtti_core.sv
// ----------------------------------------------------------------------------
// prtti_core
// Parser state and per-character step: fill and sign skipping, digit
// multiply-accumulate, and the result for a terminating character.
// ----------------------------------------------------------------------------
module prtti_core
   import prtti_pkg::*;
#(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   step,
   input  logic [7:0]             ch,
   output logic                   emit,
   output logic [VALUE_WIDTH-1:0] res_value,
   output logic [COUNT_WIDTH-1:0] res_count,
   output logic                   res_error
);

   typedef enum logic [1:0] {
      PH_START,
      PH_SIGN,
      PH_POSTFILL,
      PH_DIGITS
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   neg_ff, neg_in;

   logic [7:0]             fill;
   phase_type              after_sign;
   phase_type              ph;
   logic                   base_bad;
   logic [6:0]             dig;
   logic                   taken;
   logic                   neg;
   logic                   use_digit;
   logic [VALUE_WIDTH-1:0] mac;

   // Walk the rules for this character
   always_comb begin
      fill       = (cfg.fill_char != '0) ? cfg.fill_char : CHAR_ZERO;
      after_sign = (cfg.pad_mode == PAD_SIGN_FILL) ? PH_POSTFILL : PH_DIGITS;
      base_bad   = (cfg.number_base < BASE_MIN) || (cfg.number_base > BASE_MAX);
      dig        = digit_decode(ch, cfg.number_base, cfg.letter_case);
      ph         = phase_ff;
      taken      = 1'b0;
      neg        = neg_ff;
      use_digit  = 1'b0;
      if (ph == PH_START) begin
         if (cfg.pad_mode == PAD_FILL_SIGN && ch == fill) begin
            taken = 1'b1;
         end else begin
            ph = PH_SIGN;
         end
      end
      if (!taken && ph == PH_SIGN) begin
         if (cfg.minus_char != '0 && ch == cfg.minus_char) begin
            neg   = 1'b1;
            taken = 1'b1;
         end else if (cfg.plus_char != '0 && ch == cfg.plus_char) begin
            taken = 1'b1;
         end
         ph = after_sign;
      end
      if (!taken && ph == PH_POSTFILL) begin
         if (ch == fill) begin
            taken = 1'b1;
         end else begin
            ph = PH_DIGITS;
         end
      end
      if (!taken && dig[6]) begin
         taken     = 1'b1;
         use_digit = 1'b1;
      end
   end

   // Multiply-accumulate, wrapping at the value width
   assign mac = VALUE_WIDTH'(acc_ff * cfg.number_base) + VALUE_WIDTH'(dig[5:0]);

   // Result for a terminator or a bad base
   assign emit      = base_bad || !taken;
   assign res_error = base_bad;
   assign res_value = base_bad ? '0 : (neg_ff ? ('0 - acc_ff) : acc_ff);
   assign res_count = base_bad ? '0 : count_ff;

   // Advance the number, or clear it once a result goes out
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      if (step) begin
         if (emit) begin
            phase_in = PH_START;
            acc_in   = '0;
            count_in = '0;
            neg_in   = 1'b0;
         end else begin
            phase_in = ph;
            neg_in   = neg;
            acc_in   = use_digit ? mac : acc_ff;
            count_in = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         acc_ff   <= '0;
         count_ff <= '0;
         neg_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         neg_ff   <= neg_in;
      end
   end

endmodule

>>> rtl/core/prtti_chk.sv
// ----------------------------------------------------------------------------
// prtti_chk
// Port-level checks on the parser's result channel and input stall, bound
// to the top level.
// ----------------------------------------------------------------------------
module prtti_chk #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
)
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [VALUE_WIDTH-1:0] rsp_value,
   input logic [COUNT_WIDTH-1:0] rsp_consumed,
   input logic                   rsp_config_error
);

   // A stalled result item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) &&
      $stable(rsp_consumed) && $stable(rsp_config_error))
      else $error("result item changed while stalled");

   // A bad base reports a zero value and zero count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_error |-> rsp_value == '0 && rsp_consumed == '0)
      else $error("config error result carries data");

   // The input side only stalls behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // No result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind padded_radix_text_to_integer prtti_chk #(
   .VALUE_WIDTH (VALUE_WIDTH),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_prtti_chk (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_value        (rsp_value),
   .rsp_consumed     (rsp_consumed),
   .rsp_config_error (rsp_config_error)
);

>>> tb/sv/padded_radix_text_to_integer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_radix_text_to_integer_tb
// Self-checking bench for the radix text parser. A short scripted opening
// covers sign and fill handling, letter digits, spare mode codes and bad
// bases; random number texts follow under many register settings. Opening
// rows with hand-read results are checked against those; every other result
// is compared with an in-bench parser fed the same accepted characters.
// ----------------------------------------------------------------------------
module padded_radix_text_to_integer_tb;
   import prtti_pkg::*;

   localparam int ITEM_TARGET    = 1700;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_CYCLES    = 120;
   localparam int PRESSURE_ITEMS = 40;
   localparam int END_LIMIT      = 20000;

   // Spare codes and unused register slots
   localparam logic [1:0]           PAD_SPARE      = 2'd3;
   localparam logic [1:0]           CASE_SPARE     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI  = 3'd7;

   typedef struct packed {
      logic [63:0] value;
      logic [15:0] consumed;
      logic        config_error;
   } parse_result_type;

   localparam parse_result_type NO_RESULT = '0;

   typedef enum logic [1:0] {
      AWAIT_START,
      AWAIT_SIGN,
      SKIP_FILL,
      TAKE_DIGITS
   } scan_phase_type;
   typedef enum logic {ROW_CHAR, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [7:0]            data;
      bit                    typed;
      logic [63:0]           value;
      logic [15:0]           consumed;
      logic                  err;
   } script_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_ch;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [63:0]           rsp_value;
   logic [15:0]           rsp_consumed;
   logic                  rsp_config_error;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Parser state of the bench
   cfg_type        live_cfg;
   scan_phase_type scan_phase;
   logic [63:0]    digit_acc;
   logic [15:0]    taken_count;
   bit             minus_seen;

   parse_result_type awaited_numbers [$];
   int               mismatches;
   int               chars_sent;
   bit               long_hold;
   bit               steady;

   // Scripted opening: characters, register writes and hand-read results
   script_row_type opening_script [37] = '{
      '{ROW_CHAR, REG_NUMBER_BASE, "0", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "0", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "-", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "1", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "2", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, " ", 1'b1, 64'hFFFF_FFFF_FFFF_FFF4, 16'd5, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, " ", 1'b1, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "+", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "x", 1'b1, 64'd0, 16'd1, 1'b0},
      '{ROW_REG,  REG_NUMBER_BASE, 8'd36, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "z", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "Z", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "9", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, ".", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_NUMBER_BASE, 8'd0, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "A", 1'b1, 64'd0, 16'd0, 1'b1},
      '{ROW_REG,  REG_NUMBER_BASE, 8'd63, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, 8'hFF, 1'b1, 64'd0, 16'd0, 1'b1},
      '{ROW_REG,  REG_NUMBER_BASE, 8'd2, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_PAD_MODE, {6'd0, PAD_SIGN_FILL}, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_FILL_CHAR, 8'd0, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_MINUS_CHAR, 8'd0, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "+", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "0", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "1", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "1", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "2", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_NUMBER_BASE, 8'd16, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_PAD_MODE, {6'd0, PAD_SPARE}, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_LETTER_CASE, {6'd0, CASE_SPARE}, 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_MINUS_CHAR, "-", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_REG,  REG_PLUS_CHAR, "-", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "-", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "a", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "F", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, "f", 1'b0, 64'd0, 16'd0, 1'b0},
      '{ROW_CHAR, REG_NUMBER_BASE, 8'h00, 1'b1, 64'd0, 16'd0, 1'b0}
   };

   padded_radix_text_to_integer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_consumed     (rsp_consumed),
      .rsp_config_error (rsp_config_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("%0t: run timed out", $time);
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Bench parser
   // ------------------------------------------------------------------------
   function automatic bit base_invalid();
      return live_cfg.number_base < BASE_MIN || live_cfg.number_base > BASE_MAX;
   endfunction

   function automatic void clear_number();
      scan_phase  = AWAIT_START;
      digit_acc   = '0;
      taken_count = '0;
      minus_seen  = 1'b0;
   endfunction

   function automatic void count_char();
      if (taken_count != 16'hFFFF) begin
         taken_count = taken_count + 16'd1;
      end
   endfunction

   // Digit value of c in the live base, or -1 when c is no digit
   function automatic int digit_value(input logic [7:0] c);
      int ci;
      int b;
      ci = int'(c);
      b  = int'(live_cfg.number_base);
      if (b <= int'(BASE_DEC)) begin
         return (ci >= int'(CHAR_ZERO) && ci < int'(CHAR_ZERO) + b) ? ci - int'(CHAR_ZERO) : -1;
      end
      if (ci >= int'(CHAR_ZERO) && ci <= int'(CHAR_NINE)) begin
         return ci - int'(CHAR_ZERO);
      end
      if (live_cfg.letter_case != CASE_LOWER && ci >= int'(CHAR_UPPER_A) &&
          ci < int'(UPPER_OFS) + b) begin
         return ci - int'(UPPER_OFS);
      end
      if ((live_cfg.letter_case == CASE_ANY || live_cfg.letter_case == CASE_LOWER) &&
          ci >= int'(CHAR_LOWER_A) && ci < int'(LOWER_OFS) + b) begin
         return ci - int'(LOWER_OFS);
      end
      return -1;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      case (idx)
         REG_NUMBER_BASE: live_cfg.number_base = data[5:0];
         REG_FILL_CHAR:   live_cfg.fill_char   = data;
         REG_MINUS_CHAR:  live_cfg.minus_char  = data;
         REG_PLUS_CHAR:   live_cfg.plus_char   = data;
         REG_PAD_MODE:    live_cfg.pad_mode    = data[1:0];
         REG_LETTER_CASE: live_cfg.letter_case = data[1:0];
         default: ;
      endcase
   endfunction

   // Advance the parser by one character; emits is set when it ends a number
   function automatic void parse_char(input logic [7:0] c, output bit emits,
                                      output parse_result_type res);
      logic [7:0]     fill;
      scan_phase_type after_sign;
      int             d;
      emits      = 1'b0;
      res        = '0;
      fill       = live_cfg.fill_char != 8'd0 ? live_cfg.fill_char : CHAR_ZERO;
      after_sign = live_cfg.pad_mode == PAD_SIGN_FILL ? SKIP_FILL : TAKE_DIGITS;
      // A bad base flags every character and drops the number in progress
      if (base_invalid()) begin
         clear_number();
         emits            = 1'b1;
         res.config_error = 1'b1;
         return;
      end
      if (scan_phase == AWAIT_START) begin
         if (live_cfg.pad_mode == PAD_FILL_SIGN && c == fill) begin
            count_char();
            return;
         end
         scan_phase = AWAIT_SIGN;
      end
      // Minus is tested first, so it wins when both signs are equal
      if (scan_phase == AWAIT_SIGN) begin
         if (live_cfg.minus_char != 8'd0 && c == live_cfg.minus_char) begin
            minus_seen = 1'b1;
            count_char();
            scan_phase = after_sign;
            return;
         end
         if (live_cfg.plus_char != 8'd0 && c == live_cfg.plus_char) begin
            count_char();
            scan_phase = after_sign;
            return;
         end
         scan_phase = after_sign;
      end
      if (scan_phase == SKIP_FILL) begin
         if (c == fill) begin
            count_char();
            return;
         end
         scan_phase = TAKE_DIGITS;
      end
      d = digit_value(c);
      if (d >= 0) begin
         digit_acc = digit_acc * 64'(live_cfg.number_base) + 64'(d);
         count_char();
         return;
      end
      // Terminator: report the number and start afresh
      emits        = 1'b1;
      res.value    = minus_seen ? 64'd0 - digit_acc : digit_acc;
      res.consumed = taken_count;
      clear_number();
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int sender_gap();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Offer one character, hold it until taken, then idle for a random gap
   task automatic offer_char(input logic [7:0] c, input bit typed = 1'b0,
                             input parse_result_type given = NO_RESULT);
      parse_result_type res;
      bit               emits;
      int               gap;
      req_valid <= 1'b1;
      req_ch    <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_char(c, emits, res);
      if (emits) begin
         awaited_numbers.push_back(typed ? given : res);
      end
      chars_sent++;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write a register once every pending number has come out and the pipe is empty
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      while (awaited_numbers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] digit_char(input int d);
      bit upper;
      if (d < 10) begin
         return 8'(int'(CHAR_ZERO) + d);
      end
      case (live_cfg.letter_case)
         CASE_ANY:   upper = $urandom_range(0, 1);
         CASE_LOWER: upper = 1'b0;
         default:    upper = 1'b1;
      endcase
      return upper ? 8'(int'(UPPER_OFS) + d) : 8'(int'(LOWER_OFS) + d);
   endfunction

   // Choose a new register setting, favouring valid bases and common characters
   task automatic pick_settings();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         write_reg(REG_NUMBER_BASE, ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(37, 63)));
      end else if (r < 25) begin
         write_reg(REG_NUMBER_BASE, ($urandom_range(0, 1) != 0) ? 8'(BASE_MIN) : 8'(BASE_MAX));
      end else begin
         write_reg(REG_NUMBER_BASE, 8'($urandom_range(2, 36)));
      end
      if ($urandom_range(0, 1) != 0) begin
         r = $urandom_range(0, 99);
         write_reg(REG_MINUS_CHAR, r < 50 ? "-" : r < 65 ? 8'd0 : r < 75 ? live_cfg.plus_char
                                                               : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) != 0) begin
         r = $urandom_range(0, 99);
         write_reg(REG_PLUS_CHAR, r < 50 ? "+" : r < 65 ? 8'd0 : r < 75 ? live_cfg.minus_char
                                                              : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) != 0) begin
         r = $urandom_range(0, 99);
         write_reg(REG_FILL_CHAR, r < 40 ? "0" : r < 55 ? 8'd0 : r < 70 ? " " :
                                  r < 80 ? live_cfg.minus_char : r < 85 ? live_cfg.plus_char
                                                                      : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) != 0) begin
         write_reg(REG_PAD_MODE, ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3))
                                                          : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) != 0) begin
         write_reg(REG_LETTER_CASE, ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3))
                                                             : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
         write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI,
                   8'($urandom_range(0, 255)));
      end
   endtask

   // Send one well-formed number under the live setting: fill, sign, digits, terminator
   task automatic send_number_text();
      logic [7:0] fill;
      int         r;
      int         nd;
      fill = live_cfg.fill_char != 8'd0 ? live_cfg.fill_char : CHAR_ZERO;
      if (live_cfg.pad_mode == PAD_FILL_SIGN) begin
         repeat ($urandom_range(0, 3)) offer_char(fill);
      end
      r = $urandom_range(0, 99);
      if (r < 35 && live_cfg.minus_char != 8'd0) begin
         offer_char(live_cfg.minus_char);
      end else if (r < 55 && live_cfg.plus_char != 8'd0) begin
         offer_char(live_cfg.plus_char);
      end
      if (live_cfg.pad_mode == PAD_SIGN_FILL) begin
         repeat ($urandom_range(0, 3)) offer_char(fill);
      end
      r  = $urandom_range(0, 99);
      nd = r < 70 ? $urandom_range(0, 6) : r < 95 ? $urandom_range(7, 16) : $urandom_range(17, 30);
      repeat (nd) offer_char(digit_char($urandom_range(0, int'(live_cfg.number_base) - 1)));
      r = $urandom_range(0, 99);
      offer_char(r < 50 ? " " : r < 70 ? "," : 8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls, one long hold on request
   // ------------------------------------------------------------------------
   initial begin : stall_results
      int run_left;
      int r;
      rsp_stall = 1'b0;
      run_left  = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            run_left  = 0;
         end else if (run_left > 0) begin
            run_left--;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            r = $urandom_range(0, 99);
            run_left = r < 65 ? $urandom_range(0, 3) : r < 93 ? $urandom_range(4, 20)
                                                             : $urandom_range(40, 100);
         end else begin
            rsp_stall <= 1'b1;
            r = $urandom_range(0, 99);
            run_left = r < 75 ? $urandom_range(0, 2) : r < 95 ? $urandom_range(3, 8)
                                                             : $urandom_range(10, 30);
         end
      end
   end

   // Compare each taken result with the oldest pending number
   always @(posedge clock) begin : check_results
      parse_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_numbers.size() == 0) begin
            $display("%0t: unexpected result: expected none, got value %h consumed %0d error %b",
                     $time, rsp_value, rsp_consumed, rsp_config_error);
            mismatches++;
         end else begin
            want = awaited_numbers.pop_front();
            if (rsp_value !== want.value) begin
               $display("%0t: value mismatch: expected %h, got %h", $time, want.value, rsp_value);
               mismatches++;
            end
            if (rsp_consumed !== want.consumed) begin
               $display("%0t: consumed mismatch: expected %0d, got %0d",
                        $time, want.consumed, rsp_consumed);
               mismatches++;
            end
            if (rsp_config_error !== want.config_error) begin
               $display("%0t: config_error mismatch: expected %b, got %b",
                        $time, want.config_error, rsp_config_error);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : run_sequence
      int quota;
      int waited;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_ch     = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      long_hold  = 1'b0;
      steady     = 1'b0;
      mismatches = 0;
      chars_sent = 0;
      live_cfg   = '{RST_NUMBER_BASE, RST_FILL_CHAR, RST_MINUS_CHAR, RST_PLUS_CHAR,
                     RST_PAD_MODE, RST_LETTER_CASE};
      clear_number();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the scripted opening
      foreach (opening_script[i]) begin
         if (opening_script[i].kind == ROW_REG) begin
            write_reg(opening_script[i].idx, opening_script[i].data);
         end else begin
            offer_char(opening_script[i].data, opening_script[i].typed,
                       '{opening_script[i].value, opening_script[i].consumed,
                         opening_script[i].err});
         end
      end

      // Hold the result side off while terminators keep coming
      steady    = 1'b1;
      long_hold = 1'b1;
      repeat (PRESSURE_ITEMS) offer_char(" ");
      steady    = 1'b0;

      // Random phases: new setting, then mostly well-formed numbers with some noise
      while (chars_sent < ITEM_TARGET) begin
         pick_settings();
         steady = ($urandom_range(0, 3) == 0);
         quota  = chars_sent + (base_invalid() ? $urandom_range(10, 30) : $urandom_range(40, 200));
         while (chars_sent < quota) begin
            if (base_invalid() || $urandom_range(0, 99) >= 80) begin
               repeat ($urandom_range(1, 4)) offer_char(8'($urandom_range(0, 255)));
            end else begin
               send_number_text();
            end
         end
      end
      steady = 1'b0;

      // Drain and report
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      waited = 0;
      while (awaited_numbers.size() != 0 && waited < END_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (awaited_numbers.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_numbers.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
